[rtl/core/byte_to_hex_text_encoder_unit_macros.svh]
// Assertion macros of the hex text encoder RTL.
`ifndef BYTE_TO_HEX_TEXT_ENCODER_UNIT_MACROS_SVH
`define BYTE_TO_HEX_TEXT_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define BHTE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Delayed implication, sampled on clk, off during reset.
`define BHTE_ASSERT_AFTER2(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);
`else
`define BHTE_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define BHTE_ASSERT_AFTER2(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/bhte_pkg.sv]
// Types, constants and a helper function of the hex text encoder.
package bhte_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_INSERT_SPACE   = 2'd0;
    localparam logic [1:0] REG_UPPERCASE      = 2'd1;
    localparam logic [1:0] REG_BYTES_PER_LINE = 2'd2;
    localparam logic [1:0] REG_EOL_MODE       = 2'd3;

    // Line end kinds
    localparam logic [1:0] EOL_CRLF = 2'd0;
    localparam logic [1:0] EOL_CR   = 2'd1;
    localparam logic [1:0] EOL_LF   = 2'd2;

    // Reset values
    localparam logic        RST_INSERT_SPACE   = 1'b0;
    localparam logic        RST_UPPERCASE      = 1'b1;
    localparam logic [15:0] RST_BYTES_PER_LINE = 16'd16;
    localparam logic [1:0]  RST_EOL_MODE       = EOL_CRLF;
    localparam logic [15:0] LINE_POS_START     = 16'd1;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;

    // Character slots within one request
    localparam logic [1:0] SLOT_HI   = 2'd0;
    localparam logic [1:0] SLOT_LO   = 2'd1;
    localparam logic [1:0] SLOT_TAIL = 2'd2;
    localparam logic [1:0] SLOT_LF   = 2'd3;

    typedef struct packed {
        logic        insert_space;
        logic        uppercase;
        logic [15:0] bytes_per_line;
        logic [1:0]  eol_mode;
    } bhte_cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       uppercase;
        logic       ends_line;
        logic [1:0] eol_mode;
        logic [1:0] last_slot;
    } bhte_entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } bhte_qstat_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CHAR_UP_A : CHAR_LO_A;
            if (nib < 4'd10)
                hex_digit = CHAR_ZERO + {4'd0, nib};
            else
                hex_digit = base + {4'd0, nib - 4'd10};
        end
    endfunction

endpackage

[rtl/core/bhte_if.sv]
// Stream interfaces of the hex text encoder: byte requests in, characters out.
interface bhte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_text;

    modport source (output valid, output data_byte, output first_of_text, input ready);
    modport sink   (input valid, input data_byte, input first_of_text, output ready);
endinterface

interface bhte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

[rtl/core/bhte_front.sv]
// Front end: accept byte requests, track line position, classify the tail.
module bhte_front
    import bhte_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bhte_cfg_t    cfg,
    bhte_in_if.sink      in_ch,
    output logic         push_valid,
    input  logic         push_ready,
    output bhte_entry_t  push_entry,
    output logic [15:0]  line_pos
);

    logic [15:0] line_pos_reg;
    logic [15:0] line_pos_next;
    logic [15:0] pos_eff;
    logic        ends_line;
    logic        accept;

    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;
    assign accept      = in_ch.valid && push_ready;
    assign line_pos    = line_pos_reg;

    always_comb
    begin
        pos_eff   = in_ch.first_of_text ? LINE_POS_START : line_pos_reg;
        ends_line = 1'b0;
        line_pos_next = pos_eff;
        if (cfg.bytes_per_line != 16'd0)
        begin
            if (pos_eff >= cfg.bytes_per_line)
            begin
                ends_line     = 1'b1;
                line_pos_next = LINE_POS_START;
            end
            else
            begin
                line_pos_next = pos_eff + 16'd1;
            end
        end
    end

    // Queue entry, with the index of the final character this byte produces
    always_comb
    begin
        push_entry.data_byte = in_ch.data_byte;
        push_entry.uppercase = cfg.uppercase;
        push_entry.ends_line = ends_line;
        push_entry.eol_mode  = cfg.eol_mode;
        if (!ends_line)
            push_entry.last_slot = cfg.insert_space ? SLOT_TAIL : SLOT_LO;
        else
        begin
            unique case (cfg.eol_mode)
                EOL_CRLF: push_entry.last_slot = SLOT_LF;
                EOL_CR:   push_entry.last_slot = SLOT_TAIL;
                EOL_LF:   push_entry.last_slot = SLOT_TAIL;
                default:  push_entry.last_slot = SLOT_LO;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_pos_reg <= LINE_POS_START;
        else if (accept)
            line_pos_reg <= line_pos_next;
    end

endmodule

[rtl/core/bhte_queue.sv]
// Short request queue between front and back ends.
module bhte_queue
    import bhte_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  bhte_entry_t  push_entry,
    output logic         pop_valid,
    input  logic         pop_ready,
    output bhte_entry_t  pop_entry,
    output bhte_qstat_t  stat
);

    bhte_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    assign push_ready = !stat.full;
    assign pop_valid  = !stat.empty;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[rtl/core/bhte_back.sv]
// Back end: step through the characters of the head request, one per cycle while the sink is ready.
module bhte_back
    import bhte_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_pop,
    input  bhte_entry_t  q_entry,
    bhte_out_if.source   out_ch
);

    logic [1:0] slot_reg, slot_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic [7:0] char_now;
    logic       last_now;
    logic       load;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_char    = out_char_reg;
    assign out_ch.last_of_run = out_last_reg;

    assign load     = q_valid && (!out_valid_reg || out_ch.ready);
    assign last_now = (slot_reg == q_entry.last_slot);
    assign q_pop    = load && last_now;

    always_comb
    begin
        unique case (slot_reg)
            SLOT_HI:   char_now = hex_digit(q_entry.data_byte[7:4], q_entry.uppercase);
            SLOT_LO:   char_now = hex_digit(q_entry.data_byte[3:0], q_entry.uppercase);
            SLOT_TAIL: char_now = !q_entry.ends_line ? CHAR_SPACE :
                                  (q_entry.eol_mode == EOL_LF) ? CHAR_LF : CHAR_CR;
            SLOT_LF:   char_now = CHAR_LF;
            default:   char_now = CHAR_LF;
        endcase
    end

    always_comb
    begin
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            slot_next      = last_now ? SLOT_HI : slot_reg + 2'd1;
        end
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= SLOT_HI;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= char_now;
            out_last_reg <= last_now;
        end
    end

endmodule

[rtl/core/byte_to_hex_text_encoder_unit.sv]
// Top level of the byte to ASCII hex text encoder.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+------------------------------------
//  in_ch    | in  | valid / ready   | data_byte[7:0], first_of_text
//  out_ch   | out | valid / ready   | out_char[7:0], last_of_run
//  apb      | in  | psel / penable  | paddr[3:0], pwdata/prdata[31:0]
//
// Each byte request yields 2 to 4 characters, one per cycle while the sink
// is ready, so the back-end character sequencer sets the sustained input
// rate. On an idle block the request is first written into the queue, and
// the back end then loads the first character into the output register.
// Reset clears the line position to 1, empties the queue and loads the
// register defaults. A two-entry queue lets the front keep taking requests
// while the output register waits on a stalled sink.
`include "byte_to_hex_text_encoder_unit_macros.svh"

module byte_to_hex_text_encoder_unit
    import bhte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    bhte_in_if.sink            in_ch,
    bhte_out_if.source         out_ch
);

    bhte_cfg_t   cfg_reg;
    bhte_entry_t push_entry, pop_entry;
    bhte_qstat_t q_stat;
    logic        push_valid, push_ready;
    logic        pop_valid, pop_ready;
    logic        cfg_write;
    logic [1:0]  reg_idx;
    logic [15:0] line_pos;
    logic        idle_take;

    // Register file: pready held high, word index in paddr[3:2]
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.insert_space   <= RST_INSERT_SPACE;
            cfg_reg.uppercase      <= RST_UPPERCASE;
            cfg_reg.bytes_per_line <= RST_BYTES_PER_LINE;
            cfg_reg.eol_mode       <= RST_EOL_MODE;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_INSERT_SPACE:   cfg_reg.insert_space   <= pwdata[0];
                REG_UPPERCASE:      cfg_reg.uppercase      <= pwdata[0];
                REG_BYTES_PER_LINE: cfg_reg.bytes_per_line <= pwdata[15:0];
                REG_EOL_MODE:       cfg_reg.eol_mode       <= pwdata[1:0];
                default:            cfg_reg.eol_mode       <= cfg_reg.eol_mode;
            endcase
        end
    end

    // Read back, zero-extended to the bus width
    always_comb
    begin
        unique case (reg_idx)
            REG_INSERT_SPACE:   prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.insert_space};
            REG_UPPERCASE:      prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.uppercase};
            REG_BYTES_PER_LINE: prdata = {{(PDATA_W-16){1'b0}}, cfg_reg.bytes_per_line};
            REG_EOL_MODE:       prdata = {{(PDATA_W-2){1'b0}}, cfg_reg.eol_mode};
            default:            prdata = '0;
        endcase
    end

    // Front: take the request, advance the line position, decide the tail
    bhte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .line_pos   (line_pos)
    );

    // Decouple the two ends
    bhte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .stat       (q_stat)
    );

    // Back: emit the characters through the output register
    bhte_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_pop   (pop_ready),
        .q_entry (pop_entry),
        .out_ch  (out_ch)
    );

    // Request taken while nothing is queued and the output register is empty
    assign idle_take = in_ch.valid && in_ch.ready && q_stat.empty && !out_ch.valid;

    `BHTE_ASSERT_IMPLIES(a_line_pos_nonzero, 1'b1, line_pos != 16'd0, "line position hit zero")
    `BHTE_ASSERT_IMPLIES(a_queue_bound, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overrun")
    `BHTE_ASSERT_AFTER2(a_first_char_latency, idle_take, out_ch.valid, "late first character")

endmodule
